// ===== src/tds_pkg.sv =====
`default_nettype none
package tds_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MAX_EMIT = 16;
  localparam int CNT_W    = $clog2(MAX_EMIT + 1);

  localparam logic [1:0] OP_SCHED  = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_SCHED  = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_EXPIRE = 2'd3;

  localparam logic [31:0] HANDLE_START = 32'd10;

  typedef struct packed {
    logic accept;
    logic tick;
    logic sched;
    logic rem_step;
    logic rem_out;
    logic tick_step;
    logic tdec;
    logic tlast;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_last;
    logic best_v;
    logic held_v;
    logic cnt_max;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/tds_ctrl.sv =====
`default_nettype none
module tds_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_opcode,
  output logic               in_ready,
  input  wire tds_pkg::sts_t sts,
  output tds_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCH   = 3'd1;
  localparam logic [2:0] S_RSCAN = 3'd2;
  localparam logic [2:0] S_ROUT  = 3'd3;
  localparam logic [2:0] S_TSCAN = 3'd4;
  localparam logic [2:0] S_TDEC  = 3'd5;
  localparam logic [2:0] S_TLAST = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_opcode)
            tds_pkg::OP_SCHED:  state_nxt = S_SCH;
            tds_pkg::OP_REMOVE: state_nxt = S_RSCAN;
            tds_pkg::OP_TICK: begin
              cmd.tick  = 1'b1;
              state_nxt = S_TSCAN;
            end
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCH: begin
        if (sts.out_free) begin
          cmd.sched = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RSCAN: begin
        cmd.rem_step = 1'b1;
        if (sts.scan_last) state_nxt = S_ROUT;
      end
      S_ROUT: begin
        if (sts.out_free) begin
          cmd.rem_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_TSCAN: begin
        cmd.tick_step = 1'b1;
        if (sts.scan_last) state_nxt = S_TDEC;
      end
      S_TDEC: begin
        if (!sts.held_v || sts.out_free) begin
          cmd.tdec = 1'b1;
          if (sts.best_v) state_nxt = sts.cnt_max ? S_TLAST : S_TSCAN;
          else state_nxt = S_IDLE;
        end
      end
      S_TLAST: begin
        if (sts.out_free) begin
          cmd.tlast = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ===== src/tds_dpath.sv =====
`default_nettype none
module tds_dpath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tds_pkg::cmd_t cmd,
  output tds_pkg::sts_t      sts,
  input  wire logic [31:0]   in_delay_ms,
  input  wire logic          in_is_repeating,
  input  wire logic [31:0]   in_target_handle,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_kind,
  output logic [31:0]        out_handle,
  output logic               out_found,
  output logic               out_last
);

  localparam int CAP = tds_pkg::CAPACITY;
  localparam int IW  = tds_pkg::IDX_W;
  localparam int CW  = tds_pkg::CNT_W;

  logic [47:0] now_r;
  logic [31:0] nh_r;
  logic [CAP-1:0] vld_r;
  logic [47:0] dl_r [CAP];
  logic [31:0] hd_r [CAP];
  logic [31:0] pd_r [CAP];

  logic [31:0] dly_r, tgt_r;
  logic        rep_r;
  logic [IW-1:0] idx_r;
  logic        found_r;
  logic        best_v_r;
  logic [IW-1:0] best_idx_r;
  logic [47:0] best_dl_r;
  logic [31:0] best_h_r;
  logic        held_v_r;
  logic [31:0] held_h_r;
  logic [CW-1:0] cnt_r;

  logic        ov_r, ofound_r, olast_r;
  logic [1:0]  okind_r;
  logic [31:0] ohandle_r;

  logic        out_free;
  logic        full;
  logic [IW-1:0] free_idx;
  logic [47:0] dl_e;
  logic [31:0] hd_e;
  logic        cand, better;

  assign out_free = !ov_r || out_ready;
  assign full     = &vld_r;
  assign dl_e     = dl_r[idx_r];
  assign hd_e     = hd_r[idx_r];
  assign cand     = vld_r[idx_r] && (dl_e <= now_r);
  assign better   = !best_v_r || (dl_e < best_dl_r) ||
                    ((dl_e == best_dl_r) && (hd_e < best_h_r));

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (!vld_r[i]) free_idx = IW'(i);
    end
  end

  assign sts.out_free  = out_free;
  assign sts.scan_last = (idx_r == IW'(CAP - 1));
  assign sts.best_v    = best_v_r;
  assign sts.held_v    = held_v_r;
  assign sts.cnt_max   = (cnt_r == CW'(tds_pkg::MAX_EMIT - 1));

  // Entry store and scan control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      nh_r     <= tds_pkg::HANDLE_START;
      vld_r    <= '0;
      idx_r    <= '0;
      found_r  <= 1'b0;
      best_v_r <= 1'b0;
      held_v_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (cmd.accept) begin
        dly_r    <= in_delay_ms;
        rep_r    <= in_is_repeating;
        tgt_r    <= in_target_handle;
        idx_r    <= '0;
        found_r  <= 1'b0;
        best_v_r <= 1'b0;
        held_v_r <= 1'b0;
        cnt_r    <= '0;
      end
      // The millisecond clock moves as the tick transaction is taken, so the
      // scan that follows already compares against the new time.
      if (cmd.tick) begin
        now_r <= now_r + 48'd1;
      end
      if (cmd.sched && !full) begin
        vld_r[free_idx] <= 1'b1;
        hd_r[free_idx]  <= nh_r;
        dl_r[free_idx]  <= now_r + {16'd0, dly_r};
        pd_r[free_idx]  <= rep_r ? dly_r : 32'd0;
        nh_r            <= nh_r + 32'd1;
      end
      if (cmd.rem_step) begin
        idx_r <= idx_r + IW'(1);
        if (vld_r[idx_r] && (hd_e == tgt_r)) begin
          vld_r[idx_r] <= 1'b0;
          found_r      <= 1'b1;
        end
      end
      if (cmd.tick_step) begin
        idx_r <= idx_r + IW'(1);
        if (cand && better) begin
          best_v_r   <= 1'b1;
          best_idx_r <= idx_r;
          best_dl_r  <= dl_e;
          best_h_r   <= hd_e;
        end
      end
      if (cmd.tdec) begin
        idx_r    <= '0;
        best_v_r <= 1'b0;
        held_v_r <= best_v_r;
        if (best_v_r) begin
          held_h_r <= best_h_r;
          cnt_r    <= cnt_r + CW'(1);
          if (pd_r[best_idx_r] != 32'd0) begin
            dl_r[best_idx_r] <= now_r + {16'd0, pd_r[best_idx_r]};
          end else begin
            vld_r[best_idx_r] <= 1'b0;
          end
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (out_ready) ov_r <= 1'b0;
      if (cmd.sched) begin
        ov_r      <= 1'b1;
        okind_r   <= full ? tds_pkg::KIND_FULL : tds_pkg::KIND_SCHED;
        ohandle_r <= full ? 32'd0 : nh_r;
        ofound_r  <= 1'b0;
        olast_r   <= 1'b1;
      end
      if (cmd.rem_out) begin
        ov_r      <= 1'b1;
        okind_r   <= tds_pkg::KIND_REMOVE;
        ohandle_r <= tgt_r;
        ofound_r  <= found_r;
        olast_r   <= 1'b1;
      end
      if (cmd.tdec && held_v_r) begin
        ov_r      <= 1'b1;
        okind_r   <= tds_pkg::KIND_EXPIRE;
        ohandle_r <= held_h_r;
        ofound_r  <= 1'b0;
        olast_r   <= !best_v_r;
      end
      if (cmd.tlast) begin
        ov_r      <= 1'b1;
        okind_r   <= tds_pkg::KIND_EXPIRE;
        ohandle_r <= held_h_r;
        ofound_r  <= 1'b0;
        olast_r   <= 1'b1;
      end
    end
  end

  assign out_valid  = ov_r;
  assign out_kind   = okind_r;
  assign out_handle = ohandle_r;
  assign out_found  = ofound_r;
  assign out_last   = olast_r;

endmodule
`default_nettype wire

// ===== src/timer_deadline_scheduler.sv =====
`default_nettype none
// Schedule: the schedule state waits while the output register holds a result, then registers the answer there.
// Remove: one entry per cycle in a scan of the whole store, then the answer is registered in the output register.
// Tick: a scan of the whole store, then a decision step per expiry followed by another scan,
// and one more decision step to finish, or after sixteen expiries a closing step; a result waiting
// in the output register stalls the sequence. One transaction is processed at a time.
// Reset (rst_n low, synchronous) empties the store, clears the clock, handle counter to 10.
module timer_deadline_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_delay_ms,
  input  wire logic        in_is_repeating,
  input  wire logic [31:0] in_target_handle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_handle,
  output logic             out_found,
  output logic             out_last
);

  tds_pkg::cmd_t cmd;
  tds_pkg::sts_t sts;

  // The controller sequences the scans; the datapath owns the entry store.
  // A tick transaction advances the millisecond clock in the datapath as it is
  // accepted, and every expiry then costs one full scan of the store.
  tds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Results leave through a single output register in the datapath.
  tds_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_delay_ms      (in_delay_ms),
    .in_is_repeating  (in_is_repeating),
    .in_target_handle (in_target_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_handle       (out_handle),
    .out_found        (out_found),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tds_pkg::KIND_FULL |-> out_handle == 32'd0)
    else $error("rejected schedule carries a handle");
  a_found_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_kind == tds_pkg::KIND_REMOVE)
    else $error("found set outside a remove answer");
  a_sched_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != tds_pkg::KIND_EXPIRE |-> out_last)
    else $error("single-result transaction not marked last");
`endif

endmodule
`default_nettype wire

// ===== verif/timer_checker.sv =====
`default_nettype none
module timer_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_delay_ms,
  input  wire logic        in_is_repeating,
  input  wire logic [31:0] in_target_handle,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_kind,
  input  wire logic [31:0] out_handle,
  input  wire logic        out_found,
  input  wire logic        out_last,
  output int               fail_count,
  output int               pending_count
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] handle;
    logic        found;
    logic        last;
  } timer_result_t;

  timer_result_t result_queue[$];

  logic [47:0] clock_ms;
  logic [31:0] handle_ctr;
  logic        slot_busy[tds_pkg::CAPACITY];
  logic [47:0] slot_deadline[tds_pkg::CAPACITY];
  logic [31:0] slot_handle[tds_pkg::CAPACITY];
  logic [31:0] slot_period[tds_pkg::CAPACITY];

  task automatic push_result(input logic [1:0] kind, input logic [31:0] h, input logic fnd);
    timer_result_t r;
    r.kind = kind; r.handle = h; r.found = fnd; r.last = 1'b0;
    result_queue.push_back(r);
  endtask

  // Works out the results of one accepted transaction and updates the shadow state.
  task automatic predict_timer(input logic [1:0] op, input logic [31:0] delay,
                               input logic rep, input logic [31:0] target);
    int base;
    int slot;
    int best;
    int n;
    logic fnd;
    base = result_queue.size();
    n = 0;
    if (op == tds_pkg::OP_SCHED) begin
      slot = -1;
      for (int i = 0; i < tds_pkg::CAPACITY; i++)
        if (!slot_busy[i] && slot < 0) slot = i;
      if (slot < 0) begin
        push_result(tds_pkg::KIND_FULL, 32'd0, 1'b0);
      end else begin
        slot_busy[slot] = 1'b1;
        slot_handle[slot] = handle_ctr;
        slot_deadline[slot] = clock_ms + {16'd0, delay};
        slot_period[slot] = rep ? delay : 32'd0;
        push_result(tds_pkg::KIND_SCHED, handle_ctr, 1'b0);
        handle_ctr = handle_ctr + 32'd1;
      end
      n = 1;
    end else if (op == tds_pkg::OP_REMOVE) begin
      fnd = 1'b0;
      for (int i = 0; i < tds_pkg::CAPACITY; i++)
        if (slot_busy[i] && slot_handle[i] == target) begin
          slot_busy[i] = 1'b0;
          fnd = 1'b1;
        end
      push_result(tds_pkg::KIND_REMOVE, target, fnd);
      n = 1;
    end else if (op == tds_pkg::OP_TICK) begin
      clock_ms = clock_ms + 48'd1;
      while (n < tds_pkg::MAX_EMIT) begin
        best = -1;
        for (int i = 0; i < tds_pkg::CAPACITY; i++) begin
          if (slot_busy[i] && slot_deadline[i] <= clock_ms) begin
            if (best < 0 || slot_deadline[i] < slot_deadline[best] ||
                (slot_deadline[i] == slot_deadline[best] &&
                 slot_handle[i] < slot_handle[best]))
              best = i;
          end
        end
        if (best < 0) break;
        push_result(tds_pkg::KIND_EXPIRE, slot_handle[best], 1'b0);
        n++;
        if (slot_period[best] != 32'd0)
          slot_deadline[best] = clock_ms + {16'd0, slot_period[best]};
        else
          slot_busy[best] = 1'b0;
      end
    end
    if (n > 0) result_queue[base + n - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      clock_ms = '0;
      handle_ctr = tds_pkg::HANDLE_START;
      for (int i = 0; i < tds_pkg::CAPACITY; i++) slot_busy[i] = 1'b0;
      result_queue.delete();
      fail_count = 0;
    end else begin
      // The output side is checked first; a new result cannot appear in the same cycle.
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result kind=%0d handle=%0d", out_kind, out_handle);
          fail_count = fail_count + 1;
        end else begin
          want = result_queue.pop_front();
          if (want.kind !== out_kind || want.handle !== out_handle ||
              want.found !== out_found || want.last !== out_last) begin
            if (fail_count < 10)
              $display({"mismatch: expected kind=%0d handle=%0d found=%0d last=%0d,",
                        " got kind=%0d handle=%0d found=%0d last=%0d"},
                       want.kind, want.handle, want.found, want.last,
                       out_kind, out_handle, out_found, out_last);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        predict_timer(in_opcode, in_delay_ms, in_is_repeating, in_target_handle);
    end
    pending_count = result_queue.size();
  end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
module testbench;

  // Opcode with no operation behind it; the block must ignore it.
  localparam logic [1:0] OP_RSVD = 2'd3;

  // The clock period is four units, and reset is held low at the start of the run.
  logic clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = tds_pkg::OP_TICK;
  logic [31:0] in_delay_ms = 32'd1;
  logic        in_is_repeating = 1'b0;
  logic [31:0] in_target_handle = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_handle;
  logic        out_found;
  logic        out_last;
  int          fail_count;
  int          pending_count;

  // The receiver holds off while this is set, regardless of its random gaps.
  logic        hold_receiver = 1'b0;

  timer_deadline_scheduler dut (.*);

  timer_checker checker_inst (.*);

  // Gap lengths are mostly short, with an occasional long one.
  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Offers one transaction at the falling edge and waits for it to be accepted.
  // Valid stays high afterwards so that a following transaction can go back to back.
  task automatic send_item(input logic [1:0] op, input logic [31:0] delay,
                           input logic rep, input logic [31:0] target);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode <= op;
    in_delay_ms <= delay;
    in_is_repeating <= rep;
    in_target_handle <= target;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  // Random delays lean on small values, so that timers actually expire within the run.
  function automatic logic [31:0] random_delay();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'd0;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // The receiver idles at random, and stays off for a long stretch while held.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
        gap = ($urandom_range(0, 2) == 0) ? gap_length() : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // A watchdog ends the run when no transaction is accepted and no result is taken for a long time.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("timer_deadline_scheduler test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: extreme delays, zero delay, remove of found and missing handles,
    // ticks with and without expiry, and unknown opcode.
    send_item(tds_pkg::OP_TICK, 32'd0, 1'b0, 32'd0);
    send_item(tds_pkg::OP_SCHED, 32'd1, 1'b1, 32'd0);
    send_item(tds_pkg::OP_SCHED, 32'd0, 1'b1, 32'd0);
    send_item(tds_pkg::OP_SCHED, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
    send_item(tds_pkg::OP_SCHED, 32'd1, 1'b0, 32'd0);
    send_item(tds_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(tds_pkg::OP_TICK, 32'd0, 1'b0, 32'd0);
    send_item(tds_pkg::OP_REMOVE, 32'd0, 1'b0, 32'd10);
    send_item(tds_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'd10);
    send_item(tds_pkg::OP_REMOVE, 32'd0, 1'b0, 32'hFFFF_FFFF);
    send_item(tds_pkg::OP_REMOVE, 32'd0, 1'b0, 32'd12);
    send_item(OP_RSVD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // Fill the store past capacity with equal deadlines, then drain it in one tick.
    for (int i = 0; i < tds_pkg::CAPACITY + 2; i++)
      send_item(tds_pkg::OP_SCHED, 32'd1, 1'b0, 32'd0);
    send_item(tds_pkg::OP_TICK, 32'd0, 1'b0, 32'd0);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering, so the block stalls.
    hold_receiver <= 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_receiver <= 1'b0;
      end
      for (int i = 0; i < 8; i++)
        send_item(tds_pkg::OP_SCHED, $urandom_range(1, 3), 1'b1, 32'd0);
    join
    wait_drained();

    // Random part: mostly schedule and tick, with removes aimed at recent handles.
    for (int i = 0; i < 150; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_item(tds_pkg::OP_SCHED, random_delay(), 1'($urandom_range(0, 1)),
                           $urandom());
        3, 4: send_item(tds_pkg::OP_REMOVE, $urandom(), 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 3) == 0) ? $urandom()
                                                     : 32'd10 + $urandom_range(0, i + 30));
        default: send_item(tds_pkg::OP_TICK, $urandom(), 1'($urandom_range(0, 1)),
                           $urandom());
      endcase
      if (i == 100) wait_drained();
    end
    // Let periodic timers keep expiring for a while at the end.
    for (int i = 0; i < 20; i++) send_item(tds_pkg::OP_TICK, $urandom(), 1'b0, $urandom());
    wait_drained();
    repeat (400) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("timer_deadline_scheduler test passed");
    end else begin
      $display("timer_deadline_scheduler test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/tds_pkg.sv
src/tds_ctrl.sv
src/tds_dpath.sv
src/timer_deadline_scheduler.sv
verif/timer_checker.sv
verif/testbench.sv
